// File: sv/ssr_pkg.sv
// shared constants, types and register codes for the streaming find-and-replace core
// no dependencies; the front end, queue, back end and top level import it
`default_nettype none

package ssr_pkg;

    localparam int PATTERN_MAX = 16;                 // window depth in bytes, 1 to 16
    localparam int BYTES       = 16;                 // bytes held by the pattern registers
    localparam int CNT_W       = 5;                  // holds 0 to 16
    localparam int IDX_W       = 4;                  // byte index 0 to 15
    localparam int WIN_W       = PATTERN_MAX * 8;
    localparam int PAT_W       = BYTES * 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CNT_W-1:0] WIN_DEPTH = CNT_W'(PATTERN_MAX);
    localparam logic [CNT_W-1:0] REPL_MAX  = CNT_W'(BYTES);

    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_LO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_HI    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_LEN   = 3'd5;

    typedef struct packed {
        logic [PAT_W-1:0] search_pat;
        logic [CNT_W-1:0] find_len;
        logic [PAT_W-1:0] repl_pat;
        logic [CNT_W-1:0] repl_len;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_WIN  = 2'b01,
        JOB_REPL = 2'b10
    } job_mode_t;

    typedef struct packed {
        job_mode_t        mode;
        logic [CNT_W-1:0] n;
        logic             str_end;
        logic [15:0]      count;
        logic [PAT_W-1:0] data;
    } job_t;

endpackage

`default_nettype wire

// File: sv/ssr_if.sv
// valid/ready channel interfaces for input items and result items
// no dependencies
`default_nettype none

interface ssr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_has_byte;
    logic       in_end;

    modport source (output valid, output in_byte, output in_has_byte, output in_end,
                    input ready);
    modport sink (input valid, input in_byte, input in_has_byte, input in_end,
                  output ready);
endinterface

interface ssr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_has_byte;
    logic        out_last;
    logic        out_string_done;
    logic [15:0] match_count;

    modport source (output valid, output out_byte, output out_has_byte, output out_last,
                    output out_string_done, output match_count, input ready);
    modport sink (input valid, input out_byte, input out_has_byte, input out_last,
                  input out_string_done, input match_count, output ready);
endinterface

`default_nettype wire

// File: sv/ssr_front.sv
// front end: holds the byte window, compares it with the search pattern and
// turns each item with output or an end into a job; uses ssr_pkg and ssr_if
`default_nettype none

module ssr_front
    import ssr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    ssr_in_if.sink    in_ch,
    input  wire logic q_full,
    output logic      push,
    output job_t      push_job
);

    logic [WIN_W-1:0] win_reg, win_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [15:0]      cnt_reg, cnt_next;

    logic             accept;
    logic [CNT_W-1:0] slen, rlen, leff, fill_app, emit_n, job_n;
    logic [WIN_W-1:0] win_app;
    logic             hit, take_repl;
    logic [15:0]      cnt_after;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;

    always_comb
    begin
        slen = (cfg.find_len > WIN_DEPTH) ? WIN_DEPTH : cfg.find_len;
        rlen = (cfg.repl_len > REPL_MAX) ? REPL_MAX : cfg.repl_len;
        leff = (slen == '0) ? CNT_W'(1) : slen;

        // append the new byte at the fill position
        win_app  = win_reg;
        fill_app = fill_reg;
        if (in_ch.in_has_byte && fill_reg < WIN_DEPTH)
        begin
            fill_app = fill_reg + CNT_W'(1);
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                if (fill_reg == CNT_W'(i))
                begin
                    win_app[i*8 +: 8] = in_ch.in_byte;
                end
            end
        end

        hit = (slen != '0);
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (CNT_W'(i) < slen && win_app[i*8 +: 8] != cfg.search_pat[i*8 +: 8])
            begin
                hit = 1'b0;
            end
        end

        take_repl = 1'b0;
        emit_n    = '0;
        if (in_ch.in_has_byte)
        begin
            if (fill_app > leff)
            begin
                // search length lowered: drain down to one short of it
                emit_n = fill_app - leff + CNT_W'(1);
            end
            else if (fill_app == leff)
            begin
                if (hit)
                begin
                    take_repl = 1'b1;
                end
                else
                begin
                    emit_n = CNT_W'(1);
                end
            end
        end

        cnt_after = cnt_reg;
        if (take_repl && cnt_reg != 16'hFFFF)
        begin
            cnt_after = cnt_reg + 16'd1;
        end

        if (take_repl)
        begin
            job_n = rlen;
        end
        else if (in_ch.in_end)
        begin
            job_n = fill_app;
        end
        else
        begin
            job_n = emit_n;
        end

        push_job.mode    = take_repl ? JOB_REPL : JOB_WIN;
        push_job.n       = job_n;
        push_job.str_end = in_ch.in_end;
        push_job.count   = cnt_after;
        push_job.data    = PAT_W'(win_app);

        push = accept && (in_ch.in_end || job_n != '0);

        win_next  = win_reg;
        fill_next = fill_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            win_next = win_app >> {emit_n, 3'b000};
            if (in_ch.in_end || take_repl)
            begin
                fill_next = '0;
            end
            else
            begin
                fill_next = fill_app - emit_n;
            end
            cnt_next = in_ch.in_end ? 16'd0 : cnt_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            fill_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/ssr_queue.sv
// two-entry job queue between the front end and the emitter
// depends on ssr_pkg
`default_nettype none

module ssr_queue
    import ssr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      empty
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign pop_job = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/ssr_back.sv
// back end: steps through the current job into a registered output, one
// result per cycle unless the output stalls; depends on ssr_pkg and ssr_if
`default_nettype none

module ssr_back
    import ssr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire job_t pop_job,
    input  wire logic q_empty,
    output logic      pop,
    ssr_out_if.source out_ch
);

    job_t             cur_reg;
    logic             cur_v_reg, cur_v_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic             ov_reg, ov_next;
    logic [7:0]       byte_reg;
    logic             has_reg, last_reg, done_reg;
    logic [15:0]      mcount_reg;

    logic             out_free, emit, is_last;
    logic [7:0]       sel_byte;

    assign out_free = !ov_reg || out_ch.ready;
    assign emit     = cur_v_reg && out_free;
    assign is_last  = (cur_reg.n == '0) || ({1'b0, idx_reg} == cur_reg.n - CNT_W'(1));
    assign pop      = !q_empty && (!cur_v_reg || (emit && is_last));

    always_comb
    begin
        case (cur_reg.mode)
            JOB_REPL: sel_byte = cfg.repl_pat[{idx_reg, 3'b000} +: 8];
            JOB_WIN:  sel_byte = cur_reg.data[{idx_reg, 3'b000} +: 8];
            default:  sel_byte = 8'd0;
        endcase
        if (cur_reg.n == '0)
        begin
            // bare end with nothing to flush
            sel_byte = 8'd0;
        end

        cur_v_next = cur_v_reg;
        idx_next   = idx_reg;
        if (pop)
        begin
            cur_v_next = 1'b1;
            idx_next   = '0;
        end
        else if (emit)
        begin
            cur_v_next = !is_last;
            idx_next   = idx_reg + IDX_W'(1);
        end

        ov_next = ov_reg;
        if (emit)
        begin
            ov_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_job;
        end
        if (emit)
        begin
            byte_reg   <= sel_byte;
            has_reg    <= (cur_reg.n != '0);
            last_reg   <= is_last;
            done_reg   <= is_last && cur_reg.str_end;
            mcount_reg <= (is_last && cur_reg.str_end) ? cur_reg.count : 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_v_reg <= 1'b0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            cur_v_reg <= cur_v_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_ch.valid           = ov_reg;
    assign out_ch.out_byte        = byte_reg;
    assign out_ch.out_has_byte    = has_reg;
    assign out_ch.out_last        = last_reg;
    assign out_ch.out_string_done = done_reg;
    assign out_ch.match_count     = mcount_reg;

endmodule

`default_nettype wire

// File: sv/stream_substring_replace_core.sv
// path: a job passes through a queue slot, the current job and the output register
// throughput: one item in per cycle while the two-entry job queue has room;
//   the emitter gives one result per cycle while the output is accepted
// reset: window, fill, match count, job queue, output valid and all
//   configuration registers clear to zero
// top level: configuration registers, front end, job queue and emitter
`default_nettype none

module stream_substring_replace_core
    import ssr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    ssr_in_if.sink                     in_ch,
    ssr_out_if.source                  out_ch
);

    logic [CFG_DATA_W-1:0] s_lo_reg, s_hi_reg, r_lo_reg, r_hi_reg;
    logic [CNT_W-1:0]      s_len_reg, r_len_reg;
    cfg_t                  cfg;

    logic q_full, q_empty, push, pop;
    job_t push_job, pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_lo_reg  <= '0;
            s_hi_reg  <= '0;
            s_len_reg <= '0;
            r_lo_reg  <= '0;
            r_hi_reg  <= '0;
            r_len_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEARCH_LO:  s_lo_reg  <= cfg_data;
                REG_SEARCH_HI:  s_hi_reg  <= cfg_data;
                REG_SEARCH_LEN: s_len_reg <= cfg_data[CNT_W-1:0];
                REG_REPL_LO:    r_lo_reg  <= cfg_data;
                REG_REPL_HI:    r_hi_reg  <= cfg_data;
                REG_REPL_LEN:   r_len_reg <= cfg_data[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg.search_pat = {s_hi_reg, s_lo_reg};
    assign cfg.find_len   = s_len_reg;
    assign cfg.repl_pat   = {r_hi_reg, r_lo_reg};
    assign cfg.repl_len   = r_len_reg;

    ssr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_ch    (in_ch),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    ssr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    ssr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .pop_job (pop_job),
        .q_empty (q_empty),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire
